FILE: design/bspl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_pkg
// shared types, codes and helpers for the bsp point-in-leaf lookup block
// ----------------------------------------------------------------------------
package bspl_pkg;

  // default table sizes
  localparam int DEF_NODE_COUNT  = 1024;
  localparam int DEF_PLANE_COUNT = 1024;
  localparam int DEF_LEAF_COUNT  = 1024;

  // item modes (in_tuser)
  localparam logic [1:0] MODE_NODE  = 2'd0;
  localparam logic [1:0] MODE_PLANE = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // result status (out_tuser)
  localparam logic [1:0] ST_LEAF     = 2'd0;
  localparam logic [1:0] ST_LOAD     = 2'd1;
  localparam logic [1:0] ST_WALK_ERR = 2'd2;

  // walk cap on the step limit
  localparam logic [10:0] WALK_CAP = 11'd1024;

  // reciprocal scale for the constant-divisor reduction
  localparam int RECIP_SHIFT = 20;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       red;
    logic       wr;
    logic       node_rd;
    logic       plane_rd;
    logic       mul;
    logic       add;
    logic       step;
    logic       res_load;
    logic [1:0] res_status;
  } bspl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit_zero;
    logic is_leaf;
    logic limit_hit;
    logic out_free;
  } bspl_stat_t;

  // stored node: references already reduced to table range
  typedef struct packed {
    logic [9:0] plane;
    logic       front_leaf;
    logic [9:0] front;
    logic       back_leaf;
    logic [9:0] back;
  } bspl_node_t;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [23:0] offs;
  } bspl_plane_t;

  // quotient estimate of v / d, low by at most one
  function automatic logic [9:0] bspl_red_quot(logic [9:0] v, logic [20:0] recip);
    logic [30:0] p;
    p = 31'(v) * 31'(recip);
    return p[29:20];
  endfunction

  // remainder with one correction step
  function automatic logic [9:0] bspl_red_rem(logic [9:0] v, logic [9:0] q,
                                              logic [16:0] d);
    logic [26:0] qd;
    logic [10:0] r;
    qd = 27'(q) * 27'(d);
    r  = 11'(v) - qd[10:0];
    if (17'(r) >= d) begin
      r = r - d[10:0];
    end
    return r[9:0];
  endfunction

endpackage

FILE: design/bsp_point_leaf_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_leaf_lookup
// bsp tree point-in-leaf lookup with loadable node and plane tables
// ----------------------------------------------------------------------------
// each input beat is a node load, a plane load or a point query, chosen by
// in_tuser, and yields exactly one result beat. a query walks from root node 0;
// at every node it forms the exact dot product of the q1.14 normal and the
// q19.4 position, subtracts the plane distance scaled to match, and goes front
// on a result of zero or more, back otherwise, until a negative child names a
// leaf. each visited node passes through a node table read, a plane table read,
// three multipliers, two partial adds, and the sign test and step. a finished
// result waits while the output register is still full. loads pass through
// reference reduction and the table write; the no-op mode and a query under
// a zero limit go straight to the result. node, plane and leaf references are
// reduced modulo the table sizes when a node is loaded, so the walk loop runs
// on table addresses directly. the table contents are undefined after reset;
// walking into an entry never loaded gives an undefined answer. cfg_wdata sets
// the most node visits per query (values above 1024 act as 1024, zero makes
// every query fail at once); write it only while the block is idle. a result
// may sit in the output register while the next beat is taken in.
// ----------------------------------------------------------------------------
module bsp_point_leaf_lookup #(
  parameter int NODE_COUNT  = bspl_pkg::DEF_NODE_COUNT,
  parameter int PLANE_COUNT = bspl_pkg::DEF_PLANE_COUNT,
  parameter int LEAF_COUNT  = bspl_pkg::DEF_LEAF_COUNT
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, node_plane, child_front, child_back, normal_x, normal_y,
  // normal_z, plane_dist, pos_x, pos_y, pos_z, zero pad
  input  logic [191:0] in_tdata,
  // mode
  input  logic [1:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // leaf_index, walk_steps, zero pad
  output logic [23:0]  out_tdata,
  // status
  output logic [1:0]   out_tuser,
  // walk limit register
  input  logic         cfg_we,
  input  logic [10:0]  cfg_wdata
);
  import bspl_pkg::*;

  bspl_cmd_t  cmd;
  bspl_stat_t stat;
  logic [9:0]  leaf_index;
  logic [10:0] walk_steps;

  // sequencer: one beat at a time through load or walk
  bspl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, plane test and the output register
  bspl_dpath #(
    .NODE_COUNT  (NODE_COUNT),
    .PLANE_COUNT (PLANE_COUNT),
    .LEAF_COUNT  (LEAF_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_tuser),
    .in_fields      (in_tdata[185:0]),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_status     (out_tuser),
    .out_leaf_index (leaf_index),
    .out_walk_steps (walk_steps)
  );

  assign out_tdata = {3'b000, walk_steps, leaf_index};

endmodule

FILE: design/bspl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_ctrl
// sequencer for loads and tree walks
// ----------------------------------------------------------------------------
module bspl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [1:0]             in_mode,
  input  bspl_pkg::bspl_stat_t   stat,
  output bspl_pkg::bspl_cmd_t    cmd
);
  import bspl_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_WR    = 4'd2;
  localparam logic [3:0] S_NODE  = 4'd3;
  localparam logic [3:0] S_PLANE = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.res_status = res_r;
    in_tready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          case (in_mode) inside
            MODE_NODE, MODE_PLANE: begin
              res_nxt   = ST_LOAD;
              state_nxt = S_RED;
            end
            MODE_QUERY: begin
              if (stat.limit_zero) begin
                res_nxt   = ST_WALK_ERR;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_NODE;
              end
            end
            default: begin
              res_nxt   = ST_LOAD;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RED: begin
        cmd.red   = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_NODE: begin
        cmd.node_rd = 1'b1;
        state_nxt   = S_PLANE;
      end
      S_PLANE: begin
        cmd.plane_rd = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.step = 1'b1;
        if (stat.is_leaf) begin
          res_nxt   = ST_LEAF;
          state_nxt = S_DONE;
        end else if (stat.limit_hit) begin
          res_nxt   = ST_WALK_ERR;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NODE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/bspl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_dpath
// node and plane tables, reference reduction, plane test and result register
// ----------------------------------------------------------------------------
module bspl_dpath #(
  parameter int NODE_COUNT  = bspl_pkg::DEF_NODE_COUNT,
  parameter int PLANE_COUNT = bspl_pkg::DEF_PLANE_COUNT,
  parameter int LEAF_COUNT  = bspl_pkg::DEF_LEAF_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_mode,
  input  logic [185:0]          in_fields,
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_wdata,
  input  bspl_pkg::bspl_cmd_t   cmd,
  output bspl_pkg::bspl_stat_t  stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [1:0]            out_status,
  output logic [9:0]            out_leaf_index,
  output logic [10:0]           out_walk_steps
);
  import bspl_pkg::*;

  localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int PAW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [20:0] RECIP_N = 21'((1 << RECIP_SHIFT) / NODE_COUNT);
  localparam logic [20:0] RECIP_P = 21'((1 << RECIP_SHIFT) / PLANE_COUNT);
  localparam logic [20:0] RECIP_L = 21'((1 << RECIP_SHIFT) / LEAF_COUNT);
  localparam logic [16:0] DIV_N   = 17'(NODE_COUNT);
  localparam logic [16:0] DIV_P   = 17'(PLANE_COUNT);
  localparam logic [16:0] DIV_L   = 17'(LEAF_COUNT);

  // configuration
  logic [10:0] max_steps_r;
  logic [10:0] limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= WALK_CAP;
    end else if (cfg_we) begin
      max_steps_r <= cfg_wdata;
    end
  end

  assign limit = (max_steps_r > WALK_CAP) ? WALK_CAP : max_steps_r;

  // captured beat
  logic [1:0]  mode_r;
  logic [9:0]  entry_r;
  logic [9:0]  plane_ref_r;
  logic [10:0] front_r, back_r;
  logic [15:0] nx_r, ny_r, nz_r;
  logic [23:0] dist_r;
  logic signed [23:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r      <= in_mode;
      entry_r     <= in_fields[9:0];
      plane_ref_r <= in_fields[19:10];
      front_r     <= in_fields[30:20];
      back_r      <= in_fields[41:31];
      nx_r        <= in_fields[57:42];
      ny_r        <= in_fields[73:58];
      nz_r        <= in_fields[89:74];
      dist_r      <= in_fields[113:90];
      px_r        <= in_fields[137:114];
      py_r        <= in_fields[161:138];
      pz_r        <= in_fields[185:162];
    end
  end

  // reference reduction, two stages
  logic [9:0] front_raw, back_raw;
  logic [9:0] q_plane_r, q_front_r, q_back_r;
  logic [9:0] plane_red, front_red, back_red;

  assign front_raw = front_r[10] ? ~front_r[9:0] : front_r[9:0];
  assign back_raw  = back_r[10]  ? ~back_r[9:0]  : back_r[9:0];

  always_ff @(posedge clk) begin
    if (cmd.red) begin
      q_plane_r <= bspl_red_quot(plane_ref_r, RECIP_P);
      q_front_r <= bspl_red_quot(front_raw, front_r[10] ? RECIP_L : RECIP_N);
      q_back_r  <= bspl_red_quot(back_raw, back_r[10] ? RECIP_L : RECIP_N);
    end
  end

  assign plane_red = bspl_red_rem(plane_ref_r, q_plane_r, DIV_P);
  assign front_red = bspl_red_rem(front_raw, q_front_r, front_r[10] ? DIV_L : DIV_N);
  assign back_red  = bspl_red_rem(back_raw, q_back_r, back_r[10] ? DIV_L : DIV_N);

  // tables
  bspl_node_t  node_mem  [NODE_COUNT];
  bspl_plane_t plane_mem [PLANE_COUNT];
  bspl_node_t  node_rd_r;
  bspl_plane_t plane_rd_r;
  bspl_node_t  node_wdata;
  bspl_plane_t plane_wdata;
  logic        node_we, plane_we;
  logic [NAW-1:0] node_idx_r;

  assign node_we  = cmd.wr && (mode_r == MODE_NODE) && (17'(entry_r) < DIV_N);
  assign plane_we = cmd.wr && (mode_r == MODE_PLANE) && (17'(entry_r) < DIV_P);

  always_comb begin
    node_wdata.plane      = plane_red;
    node_wdata.front_leaf = front_r[10];
    node_wdata.front      = front_red;
    node_wdata.back_leaf  = back_r[10];
    node_wdata.back       = back_red;
    plane_wdata.nx        = nx_r;
    plane_wdata.ny        = ny_r;
    plane_wdata.nz        = nz_r;
    plane_wdata.offs      = dist_r;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[NAW'(entry_r)] <= node_wdata;
    end
    if (cmd.node_rd) begin
      node_rd_r <= node_mem[node_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_mem[PAW'(entry_r)] <= plane_wdata;
    end
    if (cmd.plane_rd) begin
      plane_rd_r <= plane_mem[PAW'(node_rd_r.plane)];
    end
  end

  // plane test: products, partial sums, sign
  logic signed [39:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [42:0] dsh_r;
  logic signed [42:0] sum_a_r, sum_b_r;
  logic signed [42:0] side_sum;
  logic               go_front;
  logic               child_leaf;
  logic [9:0]         child_val;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x_r <= $signed(plane_rd_r.nx) * px_r;
      prod_y_r <= $signed(plane_rd_r.ny) * py_r;
      prod_z_r <= $signed(plane_rd_r.nz) * pz_r;
      dsh_r    <= {{5{plane_rd_r.offs[23]}}, plane_rd_r.offs, 14'b0};
    end
    if (cmd.add) begin
      sum_a_r <= 43'(prod_x_r) + 43'(prod_y_r);
      sum_b_r <= 43'(prod_z_r) - dsh_r;
    end
  end

  assign side_sum   = sum_a_r + sum_b_r;
  assign go_front   = ~side_sum[42];
  assign child_leaf = go_front ? node_rd_r.front_leaf : node_rd_r.back_leaf;
  assign child_val  = go_front ? node_rd_r.front : node_rd_r.back;

  // walk position
  logic [10:0] steps_r;
  logic [10:0] steps_inc;
  logic [9:0]  leaf_r;

  assign steps_inc = steps_r + 11'd1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      steps_r    <= '0;
      node_idx_r <= '0;
    end else if (cmd.step) begin
      steps_r    <= steps_inc;
      node_idx_r <= NAW'(child_val);
      leaf_r     <= child_val;
    end
  end

  // result register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [9:0]  out_leaf_r;
  logic [10:0] out_steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_leaf_r   <= (cmd.res_status == ST_LEAF) ? leaf_r : 10'd0;
      out_steps_r  <= (cmd.res_status == ST_LOAD) ? 11'd0 : steps_r;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_status     = out_status_r;
  assign out_leaf_index = out_leaf_r;
  assign out_walk_steps = out_steps_r;

  assign stat.limit_zero = (limit == 11'd0);
  assign stat.is_leaf    = child_leaf;
  assign stat.limit_hit  = (steps_inc >= limit);
  assign stat.out_free   = ~out_valid_r | out_tready;

endmodule
